/* hdl/tmcr_pkg.sv */
// Shared types and constants for the text-mode cell renderer.
package tmcr_pkg;

   typedef enum logic [1:0] {
      CMD_RENDER       = 2'd0,
      CMD_FONT_LOAD    = 2'd1,
      CMD_PALETTE_LOAD = 2'd2,
      CMD_FRAME_TICK   = 2'd3
   } cmd_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNDERLINE_LINE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_START   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_END     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_ENABLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURSOR_ADDRESS = 3'd4;

   localparam logic [4:0]  RST_UNDERLINE_LINE = 5'd15;
   localparam logic [4:0]  RST_CURSOR_START   = 5'd13;
   localparam logic [4:0]  RST_CURSOR_END     = 5'd14;
   localparam logic        RST_CURSOR_ENABLE  = 1'b1;
   localparam logic [12:0] RST_CURSOR_ADDRESS = 13'd0;

   // Attribute decoding
   localparam logic [7:0] ATTR_UL_MASK  = 8'h77;
   localparam logic [7:0] ATTR_UL_VALUE = 8'h01;
   localparam logic [7:0] LINE_GFX_LO   = 8'hc0;
   localparam logic [7:0] LINE_GFX_HI   = 8'hdf;

   // Standard 16-color text palette, 6-bit levels shifted up by two
   localparam logic [23:0] DEFAULT_PALETTE [16] = '{
      24'h000000, 24'h0000a8, 24'h00a800, 24'h00a8a8,
      24'ha80000, 24'ha800a8, 24'ha85400, 24'ha8a8a8,
      24'h545454, 24'h5454fc, 24'h54fc54, 24'h54fcfc,
      24'hfc5454, 24'hfc54fc, 24'hfcfc54, 24'hfcfcfc
   };

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  char_code;
      logic [7:0]  attribute;
      logic [3:0]  glyph_line;
      logic [12:0] cell_address;
      logic [3:0]  palette_index;
      logic [23:0] load_data;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_color;
      logic [3:0]  dot_position;
      logic        last_dot;
   } rsp_type;

   // Per-cell render context, resolved when the transaction is accepted
   typedef struct packed {
      logic [3:0] fg_idx;
      logic [3:0] bg_idx;
      logic [3:0] cursor_idx;
      logic       cursor;
      logic       line_gfx;
   } cell_ctx_type;

   typedef struct packed {
      logic ready;
      logic busy;
   } seq_status_type;

endpackage

/* hdl/text_mode_cell_renderer_core.sv */
// Top level of the text-mode cell renderer: command decode, config, font and palette.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_ready | req_data (req_type)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_data (rsp_type), one per dot
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// A render transaction yields DOTS_PER_CELL dot transactions, one per cycle while
// rsp_ready is high; a new render is taken while the previous cell streams, so
// cells follow each other back to back. The dot emitter does one palette read
// per dot. From render accept to the first dot the path runs through the font
// RAM read, the emitter load and the output register.
// Font loads and frame ticks are accepted at any time.
// A palette load waits until no render is pending or streaming.
// Reset is synchronous; it restores config defaults, the palette and the frame
// counter. The font RAM is not cleared. rsp stalls back-pressure through the
// emitter into the pending slot and then req_ready for renders.
module text_mode_cell_renderer_core
   import tmcr_pkg::*;
   #(parameter int GLYPH_LINES   = 16,
     parameter int DOTS_PER_CELL = 9)
   (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
   );

   localparam int FONT_DEPTH = 256 * GLYPH_LINES;
   localparam int FONT_AW    = $clog2(FONT_DEPTH);

   // configuration registers
   logic [4:0]  underline_line_ff, underline_line_in;
   logic [4:0]  cursor_start_ff, cursor_start_in;
   logic [4:0]  cursor_end_ff, cursor_end_in;
   logic        cursor_enable_ff, cursor_enable_in;
   logic [12:0] cursor_address_ff, cursor_address_in;
   logic [4:0]  frame_ff, frame_in;

   logic           req_fire, csr_fire;
   logic           render_fire, font_we, pal_we, tick;
   seq_status_type seq_status;
   cell_ctx_type   cell_ctx;
   logic [5:0]     line_ext, line_mod;
   logic [FONT_AW-1:0] font_addr;
   logic [7:0]     font_row;
   logic [3:0]     pal_idx;
   logic [23:0]    pal_color;
   logic [3:0]     fg_idx, bg_idx;
   logic           blink_phase, underline_hit, cursor_line;

   // Renders need a free pending slot; palette loads must not change colors
   // under a cell already in flight.
   always_comb begin
      case (req_data.command)
         CMD_RENDER:       req_ready = seq_status.ready;
         CMD_PALETTE_LOAD: req_ready = !seq_status.busy;
         CMD_FONT_LOAD:    req_ready = 1'b1;
         CMD_FRAME_TICK:   req_ready = 1'b1;
         default:          req_ready = 1'b1;
      endcase
   end

   assign req_fire    = req_valid && req_ready;
   assign render_fire = req_fire && (req_data.command == CMD_RENDER);
   assign font_we     = req_fire && (req_data.command == CMD_FONT_LOAD);
   assign pal_we      = req_fire && (req_data.command == CMD_PALETTE_LOAD);
   assign tick        = req_fire && (req_data.command == CMD_FRAME_TICK);

   // font slot = char * GLYPH_LINES + line mod GLYPH_LINES; line < 2*GLYPH_LINES
   assign line_ext  = 6'(req_data.glyph_line);
   assign line_mod  = (line_ext >= 6'(GLYPH_LINES)) ? (line_ext - 6'(GLYPH_LINES)) : line_ext;
   assign font_addr = FONT_AW'(32'(req_data.char_code) * GLYPH_LINES + 32'(line_mod));

   // attribute decode, resolved against state at accept time
   assign blink_phase   = frame_ff[4];
   assign bg_idx        = req_data.attribute[7:4];
   assign fg_idx        = (blink_phase || !req_data.attribute[7]) ?
                          req_data.attribute[3:0] : bg_idx;
   assign underline_hit = ((req_data.attribute & ATTR_UL_MASK) == ATTR_UL_VALUE) &&
                          (underline_line_ff == {1'b0, req_data.glyph_line});
   assign cursor_line   = ({1'b0, req_data.glyph_line} >= cursor_start_ff) &&
                          ({1'b0, req_data.glyph_line} <= cursor_end_ff);

   always_comb begin
      cell_ctx.fg_idx     = fg_idx;
      cell_ctx.bg_idx     = underline_hit ? fg_idx : bg_idx;
      cell_ctx.cursor_idx = req_data.attribute[3:0];
      cell_ctx.cursor     = frame_ff[3] && cursor_line && cursor_enable_ff &&
                            (req_data.cell_address == cursor_address_ff);
      cell_ctx.line_gfx   = (DOTS_PER_CELL > 8) &&
                            (req_data.char_code >= LINE_GFX_LO) &&
                            (req_data.char_code <= LINE_GFX_HI);
   end

   // config port: always ready, unknown indexes dropped
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      underline_line_in = underline_line_ff;
      cursor_start_in   = cursor_start_ff;
      cursor_end_in     = cursor_end_ff;
      cursor_enable_in  = cursor_enable_ff;
      cursor_address_in = cursor_address_ff;
      if (csr_fire) begin
         case (csr_index)
            CSR_UNDERLINE_LINE: underline_line_in = csr_data[4:0];
            CSR_CURSOR_START:   cursor_start_in   = csr_data[4:0];
            CSR_CURSOR_END:     cursor_end_in     = csr_data[4:0];
            CSR_CURSOR_ENABLE:  cursor_enable_in  = csr_data[0];
            CSR_CURSOR_ADDRESS: cursor_address_in = csr_data[12:0];
            default: ;
         endcase
      end
   end

   assign frame_in = tick ? (frame_ff + 5'd1) : frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         underline_line_ff <= RST_UNDERLINE_LINE;
         cursor_start_ff   <= RST_CURSOR_START;
         cursor_end_ff     <= RST_CURSOR_END;
         cursor_enable_ff  <= RST_CURSOR_ENABLE;
         cursor_address_ff <= RST_CURSOR_ADDRESS;
         frame_ff          <= 5'd0;
      end else begin
         underline_line_ff <= underline_line_in;
         cursor_start_ff   <= cursor_start_in;
         cursor_end_ff     <= cursor_end_in;
         cursor_enable_ff  <= cursor_enable_in;
         cursor_address_ff <= cursor_address_in;
         frame_ff          <= frame_in;
      end
   end

   // Font RAM: load writes, render reads; one command per cycle so no overlap.
   tmcr_font_mem #(.DEPTH(FONT_DEPTH)) u_font (
      .clock   (clock),
      .wr_en   (font_we),
      .wr_addr (font_addr),
      .wr_data (req_data.load_data[7:0]),
      .rd_en   (render_fire),
      .rd_addr (font_addr),
      .rd_data (font_row)
   );

   tmcr_palette u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pal_we),
      .wr_idx   (req_data.palette_index),
      .wr_color (req_data.load_data),
      .rd_idx   (pal_idx),
      .rd_color (pal_color)
   );

   tmcr_dot_seq #(.DOTS_PER_CELL(DOTS_PER_CELL)) u_dot_seq (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (render_fire),
      .cell_ctx   (cell_ctx),
      .font_row   (font_row),
      .status     (seq_status),
      .pal_idx    (pal_idx),
      .pal_color  (pal_color),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_pal_write_idle: assert property (@(posedge clock) disable iff (reset)
      pal_we |-> !seq_status.busy)
      else $error("palette written while a cell is in flight");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      tick |=> frame_ff == $past(frame_ff) + 5'd1)
      else $error("frame counter did not advance on tick");

   a_render_enters_seq: assert property (@(posedge clock) disable iff (reset)
      render_fire |=> seq_status.busy)
      else $error("accepted render not held by the sequencer");

endmodule

/* hdl/tmcr_font_mem.sv */
// Font store: simple dual-port synchronous RAM (one write, one read port) with registered read data.
module tmcr_font_mem
   #(parameter int DEPTH = 4096,
     localparam int ADDR_W = $clog2(DEPTH))
   (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
   );

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tmcr_palette.sv */
// Color palette: 16 x 24-bit register file, reset to the default text palette.
module tmcr_palette
   import tmcr_pkg::*;
   (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [3:0]  wr_idx,
   input  logic [23:0] wr_color,
   input  logic [3:0]  rd_idx,
   output logic [23:0] rd_color
   );

   logic [23:0] pal_ff [16];

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_ff <= DEFAULT_PALETTE;
      end else if (wr_en) begin
         pal_ff[wr_idx] <= wr_color;
      end
   end

   assign rd_color = pal_ff[rd_idx];

endmodule

/* hdl/tmcr_dot_seq.sv */
// Dot sequencer: pending cell slot, dot emitter and output register.
module tmcr_dot_seq
   import tmcr_pkg::*;
   #(parameter int DOTS_PER_CELL = 9)
   (
   input  logic           clock,
   input  logic           reset,
   input  logic           cell_valid,
   input  cell_ctx_type   cell_ctx,
   input  logic [7:0]     font_row,
   output seq_status_type status,
   output logic [3:0]     pal_idx,
   input  logic [23:0]    pal_color,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
   );

   localparam logic [3:0] LAST_DOT = 4'(DOTS_PER_CELL - 1);

   logic         p_valid_ff, p_valid_in;
   cell_ctx_type p_ctx_ff, p_ctx_in;
   logic         e_valid_ff, e_valid_in;
   cell_ctx_type e_ctx_ff, e_ctx_in;
   logic [7:0]   e_row_ff, e_row_in;
   logic [3:0]   dot_ff, dot_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic out_free, e_fire, e_last, e_free, p_move, dot_on, ninth;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign e_fire   = e_valid_ff && out_free;
   assign e_last   = (dot_ff == LAST_DOT);
   assign e_free   = !e_valid_ff || (e_fire && e_last);
   assign p_move   = p_valid_ff && e_free;

   assign status.ready = !p_valid_ff || p_move;
   assign status.busy  = p_valid_ff || e_valid_ff;

   // dots 0..7 come from row bits 7..0; the ninth dot extends line graphics
   assign ninth  = dot_ff[3];
   assign dot_on = ninth ? (e_row_ff[0] && e_ctx_ff.line_gfx) : e_row_ff[~dot_ff[2:0]];

   always_comb begin
      if (e_ctx_ff.cursor && !ninth) begin
         pal_idx = e_ctx_ff.cursor_idx;
      end else if (dot_on) begin
         pal_idx = e_ctx_ff.fg_idx;
      end else begin
         pal_idx = e_ctx_ff.bg_idx;
      end
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      p_ctx_in   = p_ctx_ff;
      if (cell_valid) begin
         p_valid_in = 1'b1;
         p_ctx_in   = cell_ctx;
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      e_ctx_in   = e_ctx_ff;
      e_row_in   = e_row_ff;
      dot_in     = dot_ff;
      if (p_move) begin
         e_valid_in = 1'b1;
         e_ctx_in   = p_ctx_ff;
         e_row_in   = font_row;
         dot_in     = 4'd0;
      end else if (e_fire) begin
         if (e_last) begin
            e_valid_in = 1'b0;
         end else begin
            dot_in = dot_ff + 4'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (e_fire) begin
         rsp_valid_in        = 1'b1;
         rsp_in.pixel_color  = pal_color;
         rsp_in.dot_position = dot_ff;
         rsp_in.last_dot     = e_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         dot_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= p_valid_in;
         e_valid_ff   <= e_valid_in;
         dot_ff       <= dot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ctx_ff <= p_ctx_in;
      e_ctx_ff <= e_ctx_in;
      e_row_ff <= e_row_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cell_only_when_ready: assert property (@(posedge clock) disable iff (reset)
      cell_valid |-> status.ready)
      else $error("cell loaded while pending slot full");

   a_move_starts_at_dot0: assert property (@(posedge clock) disable iff (reset)
      p_move |=> e_valid_ff && dot_ff == 4'd0)
      else $error("new cell did not start at dot 0");

   a_dot_in_range: assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> dot_ff <= LAST_DOT)
      else $error("dot counter ran past the cell");

   a_last_closes_cell: assert property (@(posedge clock) disable iff (reset)
      e_fire && e_last |=> !e_valid_ff || dot_ff == 4'd0)
      else $error("emitter continued past last dot");

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the text-mode cell renderer core.
module tb;
   import tmcr_pkg::*;

   localparam int GLYPH_LINES   = 16;
   localparam int DOTS_PER_CELL = 9;
   localparam int FONT_DEPTH    = 256 * GLYPH_LINES;
   // slack after the last expected dot before the core is idled
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_OFF      = 300;
   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ITEMS = 45;

   // Standard text palette as 6-bit R/G/B levels; the DAC value is level << 2
   localparam logic [23:0] TEXT_LEVELS [16] = '{
      24'h00002a & 24'h000000, 24'h00002a, 24'h002a00, 24'h002a2a,
      24'h2a0000, 24'h2a002a, 24'h2a1500, 24'h2a2a2a,
      24'h151515, 24'h15153f, 24'h153f15, 24'h153f3f,
      24'h3f1515, 24'h3f153f, 24'h3f3f15, 24'h3f3f3f
   };

   // ------------------------------------------------------------------
   // Scoreboard: mirrors the core's registers, font, palette and frame
   // counter, expands each accepted render into its nine dots and checks
   // the dot stream in order.
   // ------------------------------------------------------------------
   class dot_scoreboard;
      logic [4:0]  underline_line;
      logic [4:0]  cursor_first;
      logic [4:0]  cursor_last;
      logic        cursor_on;
      logic [12:0] cursor_addr;
      logic [7:0]  font_rows [FONT_DEPTH];
      logic [23:0] palette [16];
      logic [4:0]  frame_count;
      rsp_type     pending_dots [$];
      int          cells, font_loads, palette_loads, ticks, dots_seen;

      function new();
         underline_line = RST_UNDERLINE_LINE;
         cursor_first   = RST_CURSOR_START;
         cursor_last    = RST_CURSOR_END;
         cursor_on      = RST_CURSOR_ENABLE;
         cursor_addr    = RST_CURSOR_ADDRESS;
         frame_count    = '0;
         for (int i = 0; i < 16; i++)
            palette[i] = {TEXT_LEVELS[i][21:16], 2'b00, TEXT_LEVELS[i][13:8], 2'b00,
                          TEXT_LEVELS[i][5:0], 2'b00};
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx,
                                   logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_UNDERLINE_LINE: underline_line = value[4:0];
            CSR_CURSOR_START:   cursor_first   = value[4:0];
            CSR_CURSOR_END:     cursor_last    = value[4:0];
            CSR_CURSOR_ENABLE:  cursor_on      = value[0];
            CSR_CURSOR_ADDRESS: cursor_addr    = value[12:0];
            default: ;
         endcase
      endfunction

      function void render_cell(req_type r);
         logic [7:0] glyph;
         logic [3:0] fg, bg, ci;
         logic       cursor, lit;
         rsp_type    d;
         glyph = font_rows[{r.char_code, r.glyph_line}];
         // background nibble includes the blink bit, as the hardware does
         bg = r.attribute[7:4];
         fg = (frame_count[4] || !r.attribute[7]) ? r.attribute[3:0] : bg;
         if ((r.attribute & ATTR_UL_MASK) == ATTR_UL_VALUE &&
             underline_line == {1'b0, r.glyph_line})
            bg = fg;
         cursor = frame_count[3] && cursor_on && r.cell_address == cursor_addr &&
                  {1'b0, r.glyph_line} >= cursor_first &&
                  {1'b0, r.glyph_line} <= cursor_last;
         for (int n = 0; n < DOTS_PER_CELL; n++) begin
            if (n < 8)
               lit = glyph[7-n];
            else
               lit = glyph[0] && r.char_code >= LINE_GFX_LO && r.char_code <= LINE_GFX_HI;
            ci = lit ? fg : bg;
            if (cursor && n < 8)
               ci = r.attribute[3:0];
            d.pixel_color  = palette[ci];
            d.dot_position = 4'(n);
            d.last_dot     = (n == DOTS_PER_CELL - 1);
            pending_dots.push_back(d);
         end
         cells++;
      endfunction

      function void take_request(req_type r);
         case (r.command)
            CMD_FONT_LOAD: begin
               font_rows[{r.char_code, r.glyph_line}] = r.load_data[7:0];
               font_loads++;
            end
            CMD_PALETTE_LOAD: begin
               palette[r.palette_index] = r.load_data;
               palette_loads++;
            end
            CMD_FRAME_TICK: begin
               frame_count = frame_count + 5'd1;
               ticks++;
            end
            default: render_cell(r);
         endcase
      endfunction

      // Returns an empty string when the dot matches the oldest expectation
      function string check_dot(rsp_type got);
         rsp_type want;
         string   why;
         why = "";
         if (pending_dots.size() == 0)
            return $sformatf("dot with nothing pending: color %06h pos %0d last %0b",
                             got.pixel_color, got.dot_position, got.last_dot);
         want = pending_dots.pop_front();
         dots_seen++;
         if (got.pixel_color !== want.pixel_color)
            why = {why, $sformatf(" pixel_color %06h want %06h",
                                  got.pixel_color, want.pixel_color)};
         if (got.dot_position !== want.dot_position)
            why = {why, $sformatf(" dot_position %0d want %0d",
                                  got.dot_position, want.dot_position)};
         if (got.last_dot !== want.last_dot)
            why = {why, $sformatf(" last_dot %0b want %0b", got.last_dot, want.last_dot)};
         if (why != "")
            why = {$sformatf("dot %0d:", dots_seen), why};
         return why;
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and DUT. All inputs start at known values.
   // ------------------------------------------------------------------
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   text_mode_cell_renderer_core #(
      .GLYPH_LINES   (GLYPH_LINES),
      .DOTS_PER_CELL (DOTS_PER_CELL)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   dot_scoreboard sb;
   int            error_count   = 0;
   int            send_idle_pct = 0;   // chance per cycle that the sender idles
   int            rcv_stall_pct = 0;   // chance per cycle that the receiver stalls
   int            hold_left     = 0;   // long receiver hold-off, counted down below
   bit            font_written [FONT_DEPTH];
   int            written_slots [$];

   task automatic report_mismatch(string what);
      if (error_count < 40)
         $display("MISMATCH at %0t ns:%s", $time, what);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge, before the DUT's
   // registers move. Dots are checked first, then new transactions feed
   // the scoreboard in acceptance order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      string why;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            why = sb.check_dot(rsp_data);
            if (why != "")
               report_mismatch(why);
         end
         if (req_valid && req_ready)
            sb.take_request(req_data);
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_data);
      end
   end

   // Receiver: random stalls, or a long hold-off while hold_left runs down
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sender side. Every task is entered at a rising edge and returns at the
   // edge where its transaction was taken; valid is left high so that the
   // next transaction can follow without a gap.
   // ------------------------------------------------------------------
   task automatic send_item(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // All fields random, so unused bits toggle on every command
   function automatic req_type random_req();
      req_type r;
      r.command       = cmd_type'($urandom_range(3));
      r.char_code     = 8'($urandom);
      r.attribute     = 8'($urandom);
      r.glyph_line    = 4'($urandom);
      r.cell_address  = 13'($urandom);
      r.palette_index = 4'($urandom);
      r.load_data     = 24'($urandom);
      return r;
   endfunction

   task automatic load_font(logic [7:0] chr, logic [3:0] gl, logic [23:0] data);
      req_type r;
      int      slot;
      r            = random_req();
      r.command    = CMD_FONT_LOAD;
      r.char_code  = chr;
      r.glyph_line = gl;
      r.load_data  = data;
      slot         = {chr, gl};
      if (!font_written[slot]) begin
         font_written[slot] = 1'b1;
         written_slots.push_back(slot);
      end
      send_item(r);
   endtask

   task automatic render(logic [7:0] chr, logic [7:0] attr, logic [3:0] gl,
                         logic [12:0] addr);
      req_type r;
      r              = random_req();
      r.command      = CMD_RENDER;
      r.char_code    = chr;
      r.attribute    = attr;
      r.glyph_line   = gl;
      r.cell_address = addr;
      send_item(r);
   endtask

   task automatic load_palette(logic [3:0] idx, logic [23:0] color);
      req_type r;
      r               = random_req();
      r.command       = CMD_PALETTE_LOAD;
      r.palette_index = idx;
      r.load_data     = color;
      send_item(r);
   endtask

   task automatic frame_tick();
      req_type r;
      r         = random_req();
      r.command = CMD_FRAME_TICK;
      send_item(r);
   endtask

   // Random render aimed at the interesting lines, attributes and addresses.
   // The glyph row must exist: either load it first or reuse a loaded one.
   task automatic random_render();
      logic [7:0]  chr, attr;
      logic [3:0]  gl;
      logic [12:0] addr;
      int          pick, slot, top;
      chr  = ($urandom_range(3) == 0) ? 8'($urandom_range(8'hdf, 8'hc0)) : 8'($urandom);
      gl   = 4'($urandom);
      pick = $urandom_range(99);
      top  = (sb.cursor_last > 15) ? 15 : sb.cursor_last;
      if (pick < 25 && sb.underline_line < 16)
         gl = sb.underline_line[3:0];
      else if (pick < 50 && sb.cursor_first <= top)
         gl = 4'($urandom_range(top, sb.cursor_first));
      attr = 8'($urandom);
      if ($urandom_range(4) == 0)
         attr = {1'($urandom), 3'b000, 1'($urandom), 3'b001};   // underline pattern
      addr = ($urandom_range(2) == 0) ? sb.cursor_addr : 13'($urandom);
      slot = {chr, gl};
      if (!font_written[slot]) begin
         if ($urandom_range(1)) begin
            load_font(chr, gl, 24'($urandom));
         end else begin
            slot = written_slots[$urandom_range(written_slots.size() - 1)];
            chr  = 8'(slot >> 4);
            gl   = 4'(slot);
         end
      end
      render(chr, attr, gl, addr);
   endtask

   task automatic random_traffic(int count);
      int kind;
      for (int i = 0; i < count; i++) begin
         kind = $urandom_range(99);
         if (kind < 55)
            random_render();
         else if (kind < 73)
            load_font(8'($urandom), 4'($urandom), 24'($urandom));
         else if (kind < 80)
            load_palette(4'($urandom), 24'($urandom));
         else
            frame_tick();
      end
   endtask

   // Drop valid, wait for every expected dot, then let the core go quiet.
   // The first wait lets the monitor log the last accepted transaction.
   task automatic drain();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending_dots.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Register writes, only while the core is idle.
   // ------------------------------------------------------------------
   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // One register setting per segment: the fixed ones hit the extremes and
   // out-of-range upper bits, the later ones are random.
   task automatic configure_segment(int s);
      logic [CSR_DATA_W-1:0] ul, first, last, en, addr;
      first = 13'($urandom_range(15));
      case (s)
         0: begin
            ul = 13'd0; first = 13'd0; last = 13'd31; en = 13'd1; addr = 13'd0;
         end
         1: begin
            ul = 13'd31; first = 13'd10; last = 13'd5; en = 13'd1; addr = 13'h1fff;
         end
         2: begin
            ul = 13'd7; first = 13'd3; last = 13'd3; en = 13'd0; addr = 13'($urandom);
         end
         3: begin
            // upper bits must be dropped: 15, 0, 31, 1
            ul = 13'h1fef; first = 13'h1fe0; last = 13'h1fff; en = 13'h1fff;
            addr = 13'($urandom);
         end
         default: begin
            ul   = {8'($urandom), 1'b0, 4'($urandom)};
            last = 13'($urandom_range(31, first));
            en   = {12'($urandom), 1'($urandom_range(3) != 0)};
            addr = 13'($urandom);
         end
      endcase
      write_csr(CSR_UNDERLINE_LINE, ul);
      write_csr(CSR_CURSOR_START, first);
      write_csr(CSR_CURSOR_END, last);
      write_csr(CSR_CURSOR_ENABLE, en);
      write_csr(CSR_CURSOR_ADDRESS, addr);
      // unused index, must change nothing
      write_csr(CSR_INDEX_W'(CSR_CURSOR_ADDRESS + 1 + $urandom_range(2)), 13'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Font extremes, ninth-dot range edges, blink, underline, palette
   // reloads and the cursor once the frame counter reaches eight.
   task automatic directed_cases();
      load_font(8'h00, 4'd0,  24'hffff81);   // high bits must be ignored
      load_font(8'hff, 4'd15, 24'h0000ff);
      load_font(8'hc0, 4'd15, 24'h0000a5);
      load_font(8'hdf, 4'd13, 24'h000033);
      load_font(8'hbf, 4'd13, 24'h000001);
      load_font(8'he0, 4'd14, 24'h0000ff);
      render(8'h00, 8'h00, 4'd0,  13'h0000);
      render(8'hff, 8'hff, 4'd15, 13'h1fff);  // blink with phase off
      render(8'hc0, 8'h01, 4'd15, 13'h1234);  // underline on the default line
      render(8'hc0, 8'h89, 4'd15, 13'h0aaa);  // underline together with blink
      render(8'hdf, 8'h1e, 4'd13, 13'h0000);  // cursor line, cursor phase off
      render(8'hbf, 8'h4f, 4'd13, 13'h0001);
      render(8'he0, 8'h70, 4'd14, 13'h1555);
      load_palette(4'd0,  24'hffffff);
      load_palette(4'd15, 24'h000000);
      render(8'h00, 8'hf0, 4'd0, 13'h0000);
      repeat (8) frame_tick();
      render(8'hdf, 8'h1e, 4'd13, 13'h0000);  // cursor drawn
      render(8'he0, 8'h97, 4'd14, 13'h0000);  // cursor ignores blink
   endtask

   // ------------------------------------------------------------------
   // Main sequence: reset, directed cells, then six segments of random
   // traffic with a new register setting each. Segments 0-1 idle the
   // sender lightly and stall the receiver hard, 2-3 the other way round,
   // 4-5 run flat out, with a long receiver hold-off at the start of 4.
   // ------------------------------------------------------------------
   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 7;
      rcv_stall_pct = 64;
      directed_cases();
      drain();

      for (int s = 0; s < SEGMENTS; s++) begin
         send_idle_pct = (s < 2) ? 7 : (s < 4) ? 64 : 0;
         rcv_stall_pct = (s < 2) ? 64 : (s < 4) ? 7 : 0;
         configure_segment(s);
         if (s == 4)
            hold_left = HOLD_OFF;
         random_traffic(SEGMENT_ITEMS);
         drain();
      end

      if (sb.pending_dots.size() != 0)
         report_mismatch($sformatf(" %0d dots never arrived", sb.pending_dots.size()));

      $display("Rendered %0d cells (%0d dots) with %0d font rows, %0d palette loads, %0d ticks",
               sb.cells, sb.dots_seen, sb.font_loads, sb.palette_loads, sb.ticks);
      $display("Seven register settings, three idle/stall mixes, one %0d-cycle output hold-off",
               HOLD_OFF);
      if (error_count == 0)
         $display("** text_mode_cell_renderer_core: PASSED **");
      else
         $display("** text_mode_cell_renderer_core: FAILED **");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("Timeout with %0d dots outstanding", sb.pending_dots.size());
      $display("** text_mode_cell_renderer_core: FAILED **");
      $finish;
   end

endmodule
